@@ sv/delayed_sound_trigger_scheduler_top_assert.svh @@
// assertion macros for the delayed sound trigger scheduler
// depends on a clock named clk and a reset named rst in the using module
`ifndef DELAYED_SOUND_TRIGGER_SCHEDULER_TOP_ASSERT_SVH
`define DELAYED_SOUND_TRIGGER_SCHEDULER_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication, ignored during reset
`define DSTS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dsts assertion failed");
// next-cycle implication, ignored during reset
`define DSTS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dsts assertion failed");
`else
`define DSTS_ASSERT_NOW(lbl, ante, cons)
`define DSTS_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ sv/dsts_pkg.sv @@
// shared types and constants of the delayed sound trigger scheduler
// no dependencies
`timescale 1ns / 1ps

package dsts_pkg;

  localparam int SLOT_COUNT_DEF   = 16;
  localparam int EFFECT_COUNT_DEF = 128;
  localparam int LEVEL_SHIFT      = 16;

  localparam logic [7:0] MASTER_RESET = 8'hFF;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_TRIGGER = 2'd1;
  localparam logic [1:0] MODE_TICK    = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [6:0] effect_id;
    logic [7:0] gain_value;
    logic [7:0] volume;
    logic [7:0] delay_ticks;
  } cmd_t;

  typedef struct packed {
    logic [6:0] out_effect;
    logic [7:0] out_level;
    logic       last;
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_A,
    S_MUL_B,
    S_FIND,
    S_TICK,
    S_FLUSH
  } state_t;

endpackage

@@ sv/dsts_gain_ram.sv @@
// per-effect gain word memory, one port, registered read
// depends on nothing but the clock
`timescale 1ns / 1ps

module dsts_gain_ram #(
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [7:0]               wdata,
  output logic [7:0]               rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ sv/delayed_sound_trigger_scheduler_top.sv @@
// top level of the delayed sound trigger scheduler
// depends on dsts_pkg, dsts_gain_ram and delayed_sound_trigger_scheduler_top_assert.svh
`timescale 1ns / 1ps
//
// usage
//   command channel: drive cmd and raise start; the word is taken at a clock
//   edge where start is high and busy is low. busy stays high until the
//   command has finished, so the block works on one word at a time.
//   result channel: res_valid marks res for exactly one cycle; the receiver
//   cannot stall it and must take every word when it is shown.
//   config channel: cfg_data is written to master_volume when cfg_valid and
//   cfg_ready are both high; cfg_ready is low while a command is in work.
// steps per command
//   load: done when the word is taken, no result.
//   trigger: S_MUL_A, then S_MUL_B, which gives the result when the delay
//   is zero and else goes on to S_FIND; one shared 16x8 multiplier is used twice
//   and the free-slot search walks one slot per cycle.
//   tick: S_TICK, then S_FLUSH; the slot sweep handles one slot per cycle,
//   each due effect leaves the block once the next due one is found, and
//   the last one follows the closing cycle with last set.
// reset
//   rst (synchronous) frees every slot, sets master_volume to 255 and
//   returns the sequencer to idle; gain words keep whatever they held.
//
module delayed_sound_trigger_scheduler_top #(
  parameter int SLOT_COUNT   = dsts_pkg::SLOT_COUNT_DEF,
  parameter int EFFECT_COUNT = dsts_pkg::EFFECT_COUNT_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  dsts_pkg::cmd_t cmd,
  output logic           res_valid,
  output dsts_pkg::res_t res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [7:0]     cfg_data
);

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam int ADDR_W = $clog2(EFFECT_COUNT);

  dsts_pkg::state_t state, state_next;

  logic [7:0] master_volume;

  // captured command and its derived flags
  dsts_pkg::cmd_t cmd_q;
  logic           in_range_q;
  logic           accept;
  logic           cmd_in_range;

  // slot pool
  logic [7:0] slot_countdown [SLOT_COUNT];
  logic [6:0] slot_effect    [SLOT_COUNT];
  logic [7:0] slot_level     [SLOT_COUNT];
  logic [SLOT_W-1:0] ptr;
  logic              ptr_last;
  logic [7:0]        cd_cur;
  logic              fire;

  // pending due effect, held until the next one or the end of the sweep
  logic       pend;
  logic [6:0] pend_effect;
  logic [7:0] pend_level;

  // shared multiplier
  logic [7:0]  gain_rd;
  logic [7:0]  gain;
  logic [15:0] prod_q;
  logic [7:0]  level_q;
  logic [15:0] mul_x;
  logic [7:0]  mul_y;
  logic [23:0] mul_p;

  // result staging from the output decode
  logic           emit;
  dsts_pkg::res_t res_next;

  assign busy      = (state != dsts_pkg::S_IDLE);
  assign cfg_ready = ~busy;
  assign accept    = start & ~busy;

  assign cmd_in_range = ({25'd0, cmd.effect_id} < 32'(EFFECT_COUNT));

  // gain memory: written by load, read at acceptance of a trigger
  dsts_gain_ram #(
    .DEPTH(EFFECT_COUNT)
  ) u_gain_ram (
    .clk  (clk),
    .we   (accept && (cmd.mode == dsts_pkg::MODE_LOAD) && cmd_in_range),
    .addr (ADDR_W'(cmd.effect_id)),
    .wdata(cmd.gain_value),
    .rdata(gain_rd)
  );

  // an effect number beyond the table scales with gain zero
  assign gain = in_range_q ? gain_rd : 8'd0;

  // first pass gain * volume, second pass that product * master
  always_comb begin
    if (state == dsts_pkg::S_MUL_B) begin
      mul_x = prod_q;
      mul_y = master_volume;
    end else begin
      mul_x = {8'd0, gain};
      mul_y = cmd_q.volume;
    end
  end
  assign mul_p = mul_x * mul_y;

  assign ptr_last = (ptr == SLOT_W'(SLOT_COUNT - 1));
  assign cd_cur   = slot_countdown[ptr];
  assign fire     = (cd_cur == 8'd1);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      dsts_pkg::S_IDLE: begin
        if (accept) begin
          case (cmd.mode)
            dsts_pkg::MODE_TRIGGER: state_next = dsts_pkg::S_MUL_A;
            dsts_pkg::MODE_TICK:    state_next = dsts_pkg::S_TICK;
            default:                state_next = dsts_pkg::S_IDLE;
          endcase
        end
      end
      dsts_pkg::S_MUL_A: state_next = dsts_pkg::S_MUL_B;
      dsts_pkg::S_MUL_B: begin
        state_next = (cmd_q.delay_ticks == 8'd0) ? dsts_pkg::S_IDLE : dsts_pkg::S_FIND;
      end
      dsts_pkg::S_FIND: begin
        if ((cd_cur == 8'd0) || ptr_last) begin
          state_next = dsts_pkg::S_IDLE;
        end
      end
      dsts_pkg::S_TICK: begin
        if (ptr_last) begin
          state_next = dsts_pkg::S_FLUSH;
        end
      end
      dsts_pkg::S_FLUSH: state_next = dsts_pkg::S_IDLE;
      default:           state_next = dsts_pkg::S_IDLE;
    endcase
  end

  // result decode
  always_comb begin
    emit     = 1'b0;
    res_next = '{out_effect: pend_effect, out_level: pend_level, last: 1'b0};
    case (state)
      dsts_pkg::S_MUL_B: begin
        if (cmd_q.delay_ticks == 8'd0) begin
          emit     = 1'b1;
          res_next = '{out_effect: cmd_q.effect_id,
                       out_level:  mul_p[dsts_pkg::LEVEL_SHIFT +: 8],
                       last:       1'b1};
        end
      end
      dsts_pkg::S_TICK: begin
        // a newly due slot pushes out the one held before it
        emit = (cd_cur != 8'd0) && fire && pend;
      end
      dsts_pkg::S_FLUSH: begin
        emit          = pend;
        res_next.last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= dsts_pkg::S_IDLE;
      master_volume <= dsts_pkg::MASTER_RESET;
      res_valid     <= 1'b0;
      pend          <= 1'b0;
      ptr           <= '0;
    end else begin
      state     <= state_next;
      res_valid <= emit;
      if (cfg_valid && cfg_ready) begin
        master_volume <= cfg_data;
      end
      case (state)
        dsts_pkg::S_IDLE: ptr <= '0;
        dsts_pkg::S_FIND: ptr <= ptr + 1'b1;
        dsts_pkg::S_TICK: begin
          ptr <= ptr + 1'b1;
          if (fire) begin
            pend <= 1'b1;
          end
        end
        dsts_pkg::S_FLUSH: pend <= 1'b0;
        default: ptr <= ptr;
      endcase
    end
  end

  // countdowns reset to zero, meaning free
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_countdown[i] <= 8'd0;
      end
    end else begin
      if ((state == dsts_pkg::S_FIND) && ((cd_cur == 8'd0) || ptr_last)) begin
        slot_countdown[ptr] <= cmd_q.delay_ticks;
      end else if ((state == dsts_pkg::S_TICK) && (cd_cur != 8'd0)) begin
        slot_countdown[ptr] <= cd_cur - 8'd1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    res <= res_next;
    if (accept) begin
      cmd_q      <= cmd;
      in_range_q <= cmd_in_range;
    end
    if (state == dsts_pkg::S_MUL_A) begin
      prod_q <= mul_p[15:0];
    end
    if (state == dsts_pkg::S_MUL_B) begin
      level_q <= mul_p[dsts_pkg::LEVEL_SHIFT +: 8];
    end
    if ((state == dsts_pkg::S_FIND) && ((cd_cur == 8'd0) || ptr_last)) begin
      slot_effect[ptr] <= cmd_q.effect_id;
      slot_level[ptr]  <= level_q;
    end
    if ((state == dsts_pkg::S_TICK) && fire) begin
      pend_effect <= slot_effect[ptr];
      pend_level  <= slot_level[ptr];
    end
  end

  `include "delayed_sound_trigger_scheduler_top_assert.svh"

  // no result can appear in the cycle right after a command is taken
  `DSTS_ASSERT_NEXT(a_no_early_result, accept, !res_valid)
  // the final word of a command is never followed straight by another
  `DSTS_ASSERT_NEXT(a_last_then_gap, res_valid && res.last, !res_valid)
  // a word that is not the last one means the sweep is still running
  `DSTS_ASSERT_NOW(a_more_pending, res_valid && !res.last, busy)
  // nothing is left pending once the sequencer is idle
  `DSTS_ASSERT_NOW(a_idle_clean, !busy, !pend)

endmodule
